[rtl/epm_pkg.sv]
// Shared types, constants and helper functions for the entropy pool twist mixer.
// No dependencies; used by epm_ctrl, epm_datapath and the top level.
package epm_pkg;

    localparam int POOL_WORDS = 2048;
    localparam int IDX_W      = $clog2(POOL_WORDS);
    localparam int WORD_W     = 32;
    localparam int ROT_W      = 5;
    localparam int TAP_COUNT  = 6;
    localparam int TAP_W      = $clog2(TAP_COUNT);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_WORDS - 1);
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

    localparam logic [ROT_W-1:0] ROT_STEP      = ROT_W'(7);
    localparam logic [ROT_W-1:0] ROT_STEP_WRAP = ROT_W'(14);

    // Offsets from the add pointer of the six words folded into a mixed word.
    localparam logic [IDX_W-1:0] TAP_OFF [TAP_COUNT] = '{
        IDX_W'(0), IDX_W'(1), IDX_W'(1638), IDX_W'(1231), IDX_W'(819), IDX_W'(411)
    };

    // Twist words from the CRC-32 polynomial, picked by the low 3 bits.
    localparam logic [WORD_W-1:0] TWIST [8] = '{
        32'h0000_0000, 32'h3b6e_20c8, 32'h76dc_4190, 32'h4db2_6158,
        32'hedb8_8320, 32'hd6d6_a3e8, 32'h9b64_c2b0, 32'ha00a_e278
    };

    typedef enum logic [1:0] {
        REQ_MIX   = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] data_word;
        logic [IDX_W-1:0]  entry_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  touched_index;
        logic [WORD_W-1:0] entry_value;
    } t_out_item;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             clearing;
    } t_ram_cmd;

    typedef struct packed {
        logic acc_load;
        logic acc_xor;
        t_req kind;
    } t_dp_ctrl;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [ROT_W-1:0] r);
        logic [2*WORD_W-1:0] d;
        d = {v, v} << r;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] w);
        return (w >> 3) ^ TWIST[w[2:0]];
    endfunction

endpackage

[rtl/epm_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module epm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/epm_ctrl.sv]
// Sequencer for the pool mixer: clearing sweep, request capture, tap reads, write-back.
// Depends on epm_pkg.
module epm_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  epm_pkg::t_in_item                 i_in,
    input  logic                              i_out_free,
    output epm_pkg::t_ram_cmd                 o_ram,
    output epm_pkg::t_dp_ctrl                 o_dp,
    output logic [epm_pkg::WORD_W-1:0]        o_word,
    output logic [epm_pkg::IDX_W-1:0]         o_idx,
    output logic                              o_finish
);

    epm_pkg::t_state r_state, n_state;
    epm_pkg::t_req   r_kind, n_kind;
    logic [epm_pkg::IDX_W-1:0]  r_cnt, n_cnt;
    logic [epm_pkg::IDX_W-1:0]  r_ptr, n_ptr;
    logic [epm_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic [epm_pkg::ROT_W-1:0]  r_rot, n_rot;
    logic [epm_pkg::WORD_W-1:0] r_data, n_data;
    logic [epm_pkg::TAP_W-1:0]  r_tap, n_tap;

    logic                       accept;
    epm_pkg::t_req              in_kind;
    logic [epm_pkg::IDX_W-1:0]  ptr_dec;

    assign in_kind = epm_pkg::t_req'(i_in.req_type);
    assign accept  = i_in_valid && o_in_ready;
    assign ptr_dec = r_ptr - epm_pkg::IDX_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            epm_pkg::ST_CLEAR: begin
                if (r_cnt == epm_pkg::IDX_LAST) n_state = epm_pkg::ST_IDLE;
            end
            epm_pkg::ST_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        epm_pkg::REQ_MIX:   n_state = epm_pkg::ST_MIX;
                        epm_pkg::REQ_WRITE: n_state = epm_pkg::ST_FINISH;
                        epm_pkg::REQ_READ:  n_state = epm_pkg::ST_READ;
                        default:            n_state = epm_pkg::ST_IDLE;
                    endcase
                end
            end
            epm_pkg::ST_MIX: begin
                if (r_tap == epm_pkg::TAP_LAST) n_state = epm_pkg::ST_FINISH;
            end
            epm_pkg::ST_READ:   n_state = epm_pkg::ST_FINISH;
            epm_pkg::ST_FINISH: begin
                if (i_out_free) n_state = epm_pkg::ST_IDLE;
            end
            default: n_state = epm_pkg::ST_IDLE;
        endcase
    end

    // Request and pointer registers
    always_comb begin
        n_kind = r_kind;
        n_cnt  = r_cnt;
        n_ptr  = r_ptr;
        n_idx  = r_idx;
        n_rot  = r_rot;
        n_data = r_data;
        n_tap  = r_tap;
        if (r_state == epm_pkg::ST_CLEAR) begin
            n_cnt = r_cnt + epm_pkg::IDX_W'(1);
        end
        if (r_state == epm_pkg::ST_MIX) begin
            n_tap = r_tap + epm_pkg::TAP_W'(1);
        end
        if (accept) begin
            n_kind = in_kind;
            n_tap  = '0;
            if (in_kind == epm_pkg::REQ_MIX) begin
                // step the pointer down, then grow the rotate amount
                n_ptr  = ptr_dec;
                n_idx  = ptr_dec;
                n_data = epm_pkg::rotl32(i_in.data_word, r_rot);
                n_rot  = r_rot + ((ptr_dec == '0) ? epm_pkg::ROT_STEP_WRAP
                                                   : epm_pkg::ROT_STEP);
            end else begin
                n_idx  = i_in.entry_index;
                n_data = i_in.data_word;
            end
        end
    end

    // Outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_ram.rd_en       = 1'b0;
        o_ram.raddr       = r_idx;
        o_ram.we          = 1'b0;
        o_ram.waddr       = r_idx;
        o_ram.clearing    = 1'b0;
        o_dp.acc_load     = 1'b0;
        o_dp.acc_xor      = 1'b0;
        o_dp.kind         = r_kind;
        case (r_state)
            epm_pkg::ST_CLEAR: begin
                o_ram.we       = 1'b1;
                o_ram.waddr    = r_cnt;
                o_ram.clearing = 1'b1;
            end
            epm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            epm_pkg::ST_MIX: begin
                o_ram.rd_en   = 1'b1;
                o_ram.raddr   = r_idx + epm_pkg::TAP_OFF[r_tap];
                o_dp.acc_load = (r_tap == '0);
                o_dp.acc_xor  = (r_tap != '0);
            end
            epm_pkg::ST_READ: begin
                o_ram.rd_en = 1'b1;
            end
            epm_pkg::ST_FINISH: begin
                // hold until the output register can take the transfer
                o_ram.we = i_out_free && (r_kind != epm_pkg::REQ_READ);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_word   = r_data;
    assign o_idx    = r_idx;
    assign o_finish = (r_state == epm_pkg::ST_FINISH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epm_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_rot   <= '0;
            r_tap   <= '0;
            r_kind  <= epm_pkg::REQ_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_rot   <= n_rot;
            r_tap   <= n_tap;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_data <= n_data;
    end

    a_no_read_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epm_pkg::ST_CLEAR) |-> !o_ram.rd_en)
        else $error("pool read during clearing sweep");

    a_write_only_clear_or_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == epm_pkg::ST_CLEAR || r_state == epm_pkg::ST_FINISH))
        else $error("pool write outside clear or finish");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epm_pkg::ST_MIX) |-> (r_tap <= epm_pkg::TAP_LAST))
        else $error("tap counter out of range");

    a_ptr_steps_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_kind == epm_pkg::REQ_MIX) |=>
            (r_ptr == epm_pkg::IDX_W'($past(r_ptr) - epm_pkg::IDX_W'(1))))
        else $error("add pointer did not step down on mix");

endmodule

[rtl/epm_datapath.sv]
// Mix datapath: folds the six tap words into the rotated input and applies the twist.
// Depends on epm_pkg.
module epm_datapath (
    input  logic                              i_clk,
    input  epm_pkg::t_dp_ctrl                 i_dp,
    input  logic [epm_pkg::WORD_W-1:0]        i_word,
    input  logic [epm_pkg::WORD_W-1:0]        i_rdata,
    output logic [epm_pkg::WORD_W-1:0]        o_value
);

    logic [epm_pkg::WORD_W-1:0] r_acc;

    // Tap data arrives in the cycle after its read; the last tap is folded in at finish.
    always_ff @(posedge i_clk) begin
        if (i_dp.acc_load) begin
            r_acc <= i_word;
        end else if (i_dp.acc_xor) begin
            r_acc <= r_acc ^ i_rdata;
        end
    end

    always_comb begin
        case (i_dp.kind)
            epm_pkg::REQ_MIX:   o_value = epm_pkg::twist_word(r_acc ^ i_rdata);
            epm_pkg::REQ_WRITE: o_value = i_word;
            epm_pkg::REQ_READ:  o_value = i_rdata;
            default:            o_value = i_rdata;
        endcase
    end

endmodule

[rtl/entropy_pool_twist_mixer.sv]
// Top level of the entropy pool twist mixer: sequencer, datapath, pool RAM, output register.
// Depends on epm_pkg, epm_ram, epm_ctrl, epm_datapath.
//
//   channel  direction  handshake                 payload
//   request  in         i_in_valid / o_in_ready   i_in  (t_in_item)
//   result   out        o_out_valid / i_out_ready o_out (t_out_item)
//
// A mix runs from the transfer through six tap reads on the single read port of the pool
// RAM, then a finish cycle that writes back and loads the output register. A direct write
// goes straight to its finish cycle; a read passes through a read state first. After reset
// a sweep zeroes all 2048 pool entries, one entry a cycle, with o_in_ready low. A result
// waits in the output register; the next request is taken meanwhile and stalls at its
// finish cycle until the register frees.
module entropy_pool_twist_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  epm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output epm_pkg::t_out_item o_out
);

    epm_pkg::t_ram_cmd          ram_cmd;
    epm_pkg::t_dp_ctrl          dp_ctrl;
    logic [epm_pkg::WORD_W-1:0] word;
    logic [epm_pkg::WORD_W-1:0] rdata;
    logic [epm_pkg::WORD_W-1:0] value;
    logic [epm_pkg::WORD_W-1:0] wdata;
    logic [epm_pkg::IDX_W-1:0]  idx;
    logic                       finish;
    logic                       out_free;
    logic                       out_load;

    logic                       r_out_valid;
    epm_pkg::t_out_item         r_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign wdata    = ram_cmd.clearing ? '0 : value;

    epm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_ram      (ram_cmd),
        .o_dp       (dp_ctrl),
        .o_word     (word),
        .o_idx      (idx),
        .o_finish   (finish)
    );

    epm_datapath u_datapath (
        .i_clk   (i_clk),
        .i_dp    (dp_ctrl),
        .i_word  (word),
        .i_rdata (rdata),
        .o_value (value)
    );

    epm_ram #(
        .WIDTH (epm_pkg::WORD_W),
        .DEPTH (epm_pkg::POOL_WORDS)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (wdata),
        .i_re    (ram_cmd.rd_en),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (rdata)
    );

    // The finish cycle of a request loads the result once the register is free.
    assign out_load = finish && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.touched_index <= idx;
            r_out.entry_value   <= value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
